// ===== hdl/aarm_pkg.sv =====
// Package for the axis-angle rotation matrix block.
// Holds the CORDIC constants and the arctangent table; no dependencies.
package aarm_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam int CORDIC_FRAC = 30;

    // Arctangent of 2^-i as a 32-bit binary angle.
    function automatic logic signed [33:0] atan_angle(input int idx);
        logic signed [33:0] v;
        begin
            v = '0;
            case (idx)
                0: v = 34'sd536870912;
                1: v = 34'sd316933406;
                2: v = 34'sd167458907;
                3: v = 34'sd85004756;
                4: v = 34'sd42667331;
                5: v = 34'sd21354465;
                6: v = 34'sd10679838;
                7: v = 34'sd5340245;
                8: v = 34'sd2670163;
                9: v = 34'sd1335087;
                10: v = 34'sd667544;
                11: v = 34'sd333772;
                12: v = 34'sd166886;
                13: v = 34'sd83443;
                14: v = 34'sd41722;
                15: v = 34'sd20861;
                16: v = 34'sd10430;
                17: v = 34'sd5215;
                18: v = 34'sd2608;
                19: v = 34'sd1304;
                20: v = 34'sd652;
                21: v = 34'sd326;
                22: v = 34'sd163;
                23: v = 34'sd81;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== hdl/aarm_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface aarm_if #(
    parameter int W = 64
) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/axis_angle_rotation_matrix.sv =====
// Axis-angle to 3x3 rotation matrix, one beat in and one beat out per cycle while the output is taken.
// Pipeline: CORDIC_STAGES (clamped to 24) cells plus three matrix steps.
// The whole pipeline stalls together when the output beat is not taken.
// Reset clears all valid flags asynchronously; payload is not reset.
module axis_angle_rotation_matrix #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRACTION_BITS = 14
) (
    input logic clk,
    input logic rst_n,
    aarm_if.sink   in_ch,
    aarm_if.source out_ch
);
    import aarm_pkg::*;

    localparam int N = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

    logic en;
    logic mv;
    assign en = !mv || out_ch.ready;
    assign in_ch.ready = en;

    // Angle reduction into the first cell.
    logic [31:0] t;
    logic        flip;
    logic [31:0] tr;
    assign t    = {in_ch.data[63:48], 16'h0000};
    assign flip = t[31] ^ t[30];
    assign tr   = flip ? t - 32'h80000000 : t;

    logic               cv [N+1];
    logic signed [33:0] cx [N+1], cy [N+1], cz [N+1];
    logic               cf [N+1];
    logic [47:0]        ca [N+1];

    assign cv[0] = in_ch.valid;
    assign cx[0] = CORDIC_GAIN;
    assign cy[0] = '0;
    assign cz[0] = 34'(signed'(tr));
    assign cf[0] = flip;
    assign ca[0] = in_ch.data[47:0];

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        aarm_cordic_cell #(.STAGE(g)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(cv[g]), .in_x(cx[g]), .in_y(cy[g]), .in_z(cz[g]),
            .in_flip(cf[g]), .in_axis(ca[g]),
            .out_valid(cv[g+1]), .out_x(cx[g+1]), .out_y(cy[g+1]),
            .out_z(cz[g+1]), .out_flip(cf[g+1]), .out_axis(ca[g+1])
        );
    end

    aarm_matrix #(.FRACTION_BITS(FRACTION_BITS)) u_matrix (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(cv[N]), .in_x(cx[N]), .in_y(cy[N]), .in_flip(cf[N]),
        .in_axis(ca[N]), .out_valid(mv), .out_data(out_ch.data)
    );

    assign out_ch.valid = mv;
endmodule

// ===== hdl/aarm_cordic_cell.sv =====
// One CORDIC micro-rotation cell with the axis carried alongside.
// Depends on aarm_pkg.
module aarm_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [33:0] in_x,
    input  logic signed [33:0] in_y,
    input  logic signed [33:0] in_z,
    input  logic               in_flip,
    input  logic [47:0]        in_axis,
    output logic               out_valid,
    output logic signed [33:0] out_x,
    output logic signed [33:0] out_y,
    output logic signed [33:0] out_z,
    output logic               out_flip,
    output logic [47:0]        out_axis
);
    import aarm_pkg::*;

    logic signed [33:0] dx, dy;
    logic signed [33:0] x_next, y_next, z_next;

    assign dx = in_y >>> STAGE;
    assign dy = in_x >>> STAGE;

    // Rotate toward zero residual angle.
    always_comb
    begin
        if (!in_z[33])
        begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - atan_angle(STAGE);
        end
        else
        begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + atan_angle(STAGE);
        end
    end

    logic valid_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_x    <= x_next;
            out_y    <= y_next;
            out_z    <= z_next;
            out_flip <= in_flip;
            out_axis <= in_axis;
        end
    end

    assign out_valid = valid_reg;
endmodule

// ===== hdl/aarm_matrix.sv =====
// Matrix stage: rounds sine/cosine, forms the nine entries over three
// registered steps. Depends on aarm_pkg.
module aarm_matrix #(
    parameter int FRACTION_BITS = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [33:0] in_x,
    input  logic signed [33:0] in_y,
    input  logic               in_flip,
    input  logic [47:0]        in_axis,
    output logic               out_valid,
    output logic [143:0]       out_data
);
    import aarm_pkg::*;

    localparam int SH = CORDIC_FRAC - FRACTION_BITS;
    localparam int F2 = 2 * FRACTION_BITS;

    // Step 1: sign fix and rounding of cosine and sine.
    logic signed [34:0] xf, yf, cr, sr;
    assign xf = in_flip ? -35'(in_x) : 35'(in_x);
    assign yf = in_flip ? -35'(in_y) : 35'(in_y);
    assign cr = (xf + (35'sd1 <<< (SH - 1))) >>> SH;
    assign sr = (yf + (35'sd1 <<< (SH - 1))) >>> SH;

    logic               v1_reg, v2_reg, v3_reg;
    logic signed [32:0] c1_reg, s1_reg, omc1_reg;
    logic signed [15:0] a1_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg   <= 33'(cr);
            s1_reg   <= 33'(sr);
            omc1_reg <= 33'((35'sd1 <<< FRACTION_BITS) - cr);
            a1_reg[0] <= in_axis[15:0];
            a1_reg[1] <= in_axis[31:16];
            a1_reg[2] <= in_axis[47:32];
        end
    end

    // Step 2: axis pair products and sine terms.
    logic signed [31:0] pp2_reg [3][3];
    logic signed [49:0] st2_reg [3];
    logic signed [32:0] c2_reg, omc2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                    pp2_reg[i][j] <= 32'(a1_reg[i]) * 32'(a1_reg[j]);
                st2_reg[i] <= 50'(a1_reg[i]) * 50'(s1_reg);
            end
            c2_reg   <= c1_reg;
            omc2_reg <= omc1_reg;
        end
    end

    // Step 3: quadratic terms times (1-c), round, add, saturate.
    logic signed [65:0] qt [3][3];
    logic signed [49:0] sn [3];
    logic signed [66:0] sum [3][3];
    logic [15:0]        ent [3][3];

    function automatic logic [15:0] sat16(input logic signed [66:0] v);
        begin
            if (v > 67'sd32767)
                return 16'h7fff;
            else if (v < -67'sd32768)
                return 16'h8000;
            else
                return v[15:0];
        end
    endfunction

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sn[i] = (st2_reg[i] + (50'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
            for (int j = 0; j < 3; j++)
                qt[i][j] = ((66'(pp2_reg[i][j]) * 66'(omc2_reg))
                           + (66'sd1 <<< (F2 - 1))) >>> F2;
        end
        sum[0][0] = 67'(qt[0][0]) + 67'(c2_reg);
        sum[0][1] = 67'(qt[1][0]) - 67'(sn[2]);
        sum[0][2] = 67'(qt[2][0]) + 67'(sn[1]);
        sum[1][0] = 67'(qt[0][1]) + 67'(sn[2]);
        sum[1][1] = 67'(qt[1][1]) + 67'(c2_reg);
        sum[1][2] = 67'(qt[2][1]) - 67'(sn[0]);
        sum[2][0] = 67'(qt[0][2]) - 67'(sn[1]);
        sum[2][1] = 67'(qt[1][2]) + 67'(sn[0]);
        sum[2][2] = 67'(qt[2][2]) + 67'(c2_reg);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                ent[i][j] = sat16(sum[i][j]);
    end

    logic [143:0] data3_reg;
    always_ff @(posedge clk)
    begin
        if (en)
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    data3_reg[(i*3+j)*16 +: 16] <= ent[i][j];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = data3_reg;
endmodule

// ===== hdl/aarm_checker.sv =====
// Port checker for the rotation matrix block, bound to the top level.
// Depends on aarm_if through the top level's ports.
module aarm_checker (
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [143:0] out_data
);
    // A stalled output beat holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // Input is taken whenever the output is free.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // Input is held off only by a stalled output.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without cause");
endmodule

bind axis_angle_rotation_matrix aarm_checker u_aarm_checker (
    .clk(clk), .rst_n(rst_n),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_data(out_ch.data)
);
